// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the index search RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked on every clock edge outside reset
`define IAIDX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define IAIDX_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IAIDX_ASSERT(lbl, prop, msg)
`define IAIDX_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- src/iaidx_pkg.sv -----
// ----------------------------------------------------------------------------
// iaidx_pkg
// Types and constants of the instruction address index search block.
// ----------------------------------------------------------------------------
package iaidx_pkg;

	localparam int MAX_ENTRIES = 65536;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int POS_W       = IDX_W + 1;
	localparam int VA_W        = 64;
	localparam int FOFS_W      = 32;
	localparam int LEN_W       = 4;

	typedef enum logic [2:0] {
		MODE_CLEAR   = 3'd0,
		MODE_SECTION = 3'd1,
		MODE_APPEND  = 3'd2,
		MODE_FIND    = 3'd3,
		MODE_LOWER   = 3'd4
	} iaidx_mode_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} iaidx_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_RESULT
	} iaidx_state_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic [VA_W-1:0]   address;
		logic [FOFS_W-1:0] file_offset;
		logic [LEN_W-1:0]  length;
		logic              decoded_ok;
	} iaidx_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] position;
	} iaidx_rsp_t;

	// sequencer -> search unit
	typedef struct packed {
		logic             start;
		logic [POS_W-1:0] count;
		logic [VA_W-1:0]  query;
	} srch_ctl_t;

	// search unit -> sequencer
	typedef struct packed {
		logic             done;
		logic             hit;
		logic [POS_W-1:0] pos;
	} srch_sts_t;

endpackage

// ----- src/iaidx_ram.sv -----
// ----------------------------------------------------------------------------
// iaidx_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module iaidx_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/iaidx_search.sv -----
// ----------------------------------------------------------------------------
// iaidx_search
// Lower-bound binary search unit: one table probe per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iaidx_search import iaidx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  srch_ctl_t        ctl,
	input  logic [VA_W-1:0]  rd_data,
	output logic [IDX_W-1:0] rd_idx,
	output srch_sts_t        sts
);

	logic [POS_W-1:0] lo_q, hi_q, mid_q;
	logic [POS_W-1:0] lo_d, hi_d, mid_d;
	logic [VA_W-1:0]  query_q;
	logic             eq_q, eq_d;
	logic             act_q, act_d;
	logic             done_q, done_d;
	logic             step;

	always_comb begin
		lo_d = lo_q;
		hi_d = hi_q;
		eq_d = eq_q;
		if (ctl.start) begin
			lo_d = '0;
			hi_d = ctl.count;
			eq_d = 1'b0;
		end else if (act_q) begin
			if (rd_data < query_q) begin
				lo_d = mid_q + POS_W'(1);
			end else begin
				hi_d = mid_q;
				// entry at the final lower bound is the last one that moved hi
				eq_d = (rd_data == query_q);
			end
		end
		mid_d  = lo_d + ((hi_d - lo_d) >> 1);
		step   = ctl.start || act_q;
		act_d  = step && (lo_d < hi_d);
		done_d = step && !(lo_d < hi_d);
	end

	// mid < hi <= MAX_ENTRIES, so the low bits are the full index
	assign rd_idx = mid_d[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			act_q  <= act_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		eq_q  <= eq_d;
		if (ctl.start) begin
			query_q <= ctl.query;
		end
	end

	assign sts.done = done_q;
	assign sts.hit  = eq_q;
	assign sts.pos  = lo_q;

	`IAIDX_ASSERT(a_mid_in_window, act_q |-> (lo_q <= mid_q && mid_q < hi_q), "probe outside window")
	`IAIDX_ASSERT(a_no_restart, act_q |-> !ctl.start, "search restarted while probing")

endmodule

// ----- src/instruction_address_index_search.sv -----
// ----------------------------------------------------------------------------
// instruction_address_index_search
// Instruction start address table with append and binary lower-bound search.
// ----------------------------------------------------------------------------
// One request at a time. Clear, section start, append and the unused modes
// load the result register on acceptance; the result state then copies it
// into the output register and the block returns to idle. Exact find and
// lower bound run a binary search over the filled entries with one read of
// the single-port address table per cycle. A search over n entries takes at
// most floor(log2 n) + 1 probes (17 with a full table). Its result goes from
// the search unit into the result register and then, in the result state,
// into the output register. A stalled output holds the block in the result
// state. Entries are expected in ascending address order. The response
// register lets a new request be taken while the previous response is still
// waiting.
`include "assert_macros.svh"

module instruction_address_index_search import iaidx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  iaidx_req_t in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output iaidx_rsp_t out_data
);

	iaidx_state_t     state_q, state_d;
	logic [POS_W-1:0] count_q;
	logic [VA_W-1:0]  next_addr_q;
	logic             find_q;
	iaidx_rsp_t       res_q;
	iaidx_rsp_t       out_q;
	logic             out_valid_q;

	logic             accept;
	logic             load_out;
	logic             is_search;
	logic             is_append;
	logic             full;
	logic [LEN_W-1:0] step;

	logic             ram_we;
	logic [IDX_W-1:0] ram_idx;
	logic [IDX_W-1:0] srch_idx;
	logic [VA_W-1:0]  ram_rdata;
	srch_ctl_t        srch_ctl;
	srch_sts_t        srch_sts;

	assign full      = (count_q == POS_W'(MAX_ENTRIES));
	assign is_search = (in_data.mode == MODE_FIND) || (in_data.mode == MODE_LOWER);
	assign is_append = (in_data.mode == MODE_APPEND);
	// failed decode or zero length both advance by one byte
	assign step      = (in_data.decoded_ok && in_data.length != '0) ? in_data.length
		: LEN_W'(1);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = is_search ? S_SEARCH : S_RESULT;
				end
			end
			S_SEARCH: begin
				if (srch_sts.done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign accept = in_valid && in_ready;
	assign ram_we = accept && is_append && !full;
	// count_q < MAX_ENTRIES whenever a write happens
	assign ram_idx = ram_we ? count_q[IDX_W-1:0] : srch_idx;

	assign srch_ctl.start = accept && is_search;
	assign srch_ctl.count = count_q;
	assign srch_ctl.query = in_data.address;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			next_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (in_data.mode)
					MODE_CLEAR: count_q <= '0;
					MODE_SECTION: next_addr_q <= in_data.address;
					MODE_APPEND: begin
						if (!full) begin
							count_q     <= count_q + POS_W'(1);
							next_addr_q <= next_addr_q + VA_W'(step);
						end
					end
					default: ;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			find_q <= (in_data.mode == MODE_FIND);
			unique case (in_data.mode)
				MODE_SECTION: res_q <= '{status: STAT_OK, position: count_q};
				MODE_APPEND: res_q <= '{status: full ? STAT_FULL : STAT_OK,
					position: count_q};
				default: res_q <= '{status: STAT_OK, position: '0};
			endcase
		end else if (state_q == S_SEARCH && srch_sts.done) begin
			res_q <= '{status: (find_q && !srch_sts.hit) ? STAT_MISS : STAT_OK,
				position: srch_sts.pos};
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	iaidx_ram #(
		.DEPTH(MAX_ENTRIES),
		.WIDTH(VA_W)
	) u_addr_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_idx),
		.wdata(next_addr_q),
		.rdata(ram_rdata)
	);

	iaidx_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (srch_ctl),
		.rd_data(ram_rdata),
		.rd_idx (srch_idx),
		.sts    (srch_sts)
	);

	`IAIDX_ASSERT(a_count_bound, count_q <= POS_W'(MAX_ENTRIES), "entry count overflow")
	`IAIDX_ASSERT(a_done_in_search, srch_sts.done |-> (state_q == S_SEARCH), "stray search done")
	`IAIDX_ASSERT(a_write_on_append, ram_we |-> (accept && is_append && !full), "bad table write")
	`IAIDX_ASSERT(a_result_shown, load_out |=> out_valid, "response not presented")

endmodule

// ----- dv/instruction_address_index_search_test.sv -----
// ----------------------------------------------------------------------------
// instruction_address_index_search_test
// Self-checking bench for the instruction address index search block.
// ----------------------------------------------------------------------------
// Requests go in over a valid/ready channel and every response is checked
// against an in-bench model of the entry table and running position. A short
// table of hand-picked requests comes first: empty table, spare modes,
// zero-length and failed-decode appends, and address wrap. Random sequences
// of section start, appends and searches follow under three back-pressure
// mixes, with one long output stall. The run ends by building a table of
// several hundred entries and searching it end to end.

module instruction_address_index_search_test;
	import iaidx_pkg::*;

	localparam logic [2:0] MODE_SPARE5 = 3'd5;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 10;
	localparam int FILL_ENTRIES = 512;

	typedef struct packed {
		iaidx_req_t req;
		logic       typed;
		iaidx_rsp_t rsp;
	} stim_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	iaidx_req_t in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	iaidx_rsp_t out_data;

	// model of the table and the running position
	logic [VA_W-1:0]   model_addr [MAX_ENTRIES];
	logic [FOFS_W-1:0] model_ofs [MAX_ENTRIES];
	int unsigned       model_count = 0;
	logic [VA_W-1:0]   run_address = '0;
	logic [FOFS_W-1:0] run_offset = '0;

	iaidx_rsp_t  due_responses[$];
	stim_row_t   directed_rows[$];
	int unsigned sent_total = 0;
	int unsigned checked_total = 0;
	int unsigned mismatch_count = 0;
	int unsigned mode_seen [8];
	int unsigned full_appends = 0;
	int unsigned exact_hits = 0;
	int unsigned peak_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_pending = 0;

	instruction_address_index_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned first_not_below(logic [VA_W-1:0] query);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = model_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (model_addr[mid] < query)
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic iaidx_rsp_t predict_index_op(iaidx_req_t req);
		iaidx_rsp_t       rsp;
		logic [LEN_W-1:0] step;
		int unsigned      slot;
		rsp.status = STAT_OK;
		rsp.position = '0;
		case (req.mode)
			MODE_CLEAR: model_count = 0;
			MODE_SECTION: begin
				run_address = req.address;
				run_offset = req.file_offset;
				rsp.position = POS_W'(model_count);
			end
			MODE_APPEND: begin
				step = req.decoded_ok ? req.length : LEN_W'(1);
				if (step == 0)
					step = LEN_W'(1);
				rsp.position = POS_W'(model_count);
				if (model_count >= MAX_ENTRIES) begin
					rsp.status = STAT_FULL;
				end else begin
					model_addr[model_count] = run_address;
					model_ofs[model_count] = run_offset;
					model_count++;
					run_address = run_address + VA_W'(step);
					run_offset = run_offset + FOFS_W'(step);
				end
			end
			MODE_FIND: begin
				slot = first_not_below(req.address);
				rsp.position = POS_W'(slot);
				if (slot >= model_count || model_addr[slot] != req.address)
					rsp.status = STAT_MISS;
			end
			MODE_LOWER: rsp.position = POS_W'(first_not_below(req.address));
			default: ;
		endcase
		return rsp;
	endfunction

	function automatic iaidx_req_t random_req();
		iaidx_req_t r;
		r.mode = 3'($urandom_range(7));
		r.address = {$urandom, $urandom};
		r.file_offset = $urandom;
		r.length = 4'($urandom_range(15));
		r.decoded_ok = 1'($urandom_range(1));
		return r;
	endfunction

	// offer one request, wait for it to be taken, then log what it should return
	task automatic send_req(input iaidx_req_t req, input logic typed,
			input iaidx_rsp_t given);
		iaidx_rsp_t rsp;
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		rsp = predict_index_op(req);
		if (typed)
			rsp = given;
		due_responses = {due_responses, rsp};
		sent_total++;
		mode_seen[req.mode]++;
		if (rsp.status == STAT_FULL)
			full_appends++;
		if (req.mode == MODE_FIND && rsp.status == STAT_OK)
			exact_hits++;
		if (model_count > peak_count)
			peak_count = model_count;
	endtask

	task automatic add_row(input logic [2:0] mode, input logic [VA_W-1:0] addr,
			input logic [FOFS_W-1:0] ofs, input logic [LEN_W-1:0] len, input logic ok,
			input logic typed, input logic [1:0] status, input logic [POS_W-1:0] pos);
		stim_row_t row;
		row.req.mode = mode;
		row.req.address = addr;
		row.req.file_offset = ofs;
		row.req.length = len;
		row.req.decoded_ok = ok;
		row.typed = typed;
		row.rsp.status = status;
		row.rsp.position = pos;
		directed_rows = {directed_rows, row};
	endtask

	task automatic run_random(input int unsigned quota);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned n;
		int unsigned idx;
		iaidx_req_t  r;
		stop_at = sent_total + quota;
		while (sent_total < stop_at) begin
			pick = $urandom_range(99);
			r = random_req();
			if (pick < 8) begin
				send_req(r, 1'b0, '0);
			end else if (pick < 13 || model_count > 300) begin
				r.mode = MODE_CLEAR;
				send_req(r, 1'b0, '0);
			end else begin
				// mostly continue upward from the running address so the table stays sorted
				r.mode = MODE_SECTION;
				if ($urandom_range(3) != 0)
					r.address = run_address + VA_W'($urandom_range(64));
				send_req(r, 1'b0, '0);
				n = $urandom_range(24, 1);
				repeat (n) begin
					r = random_req();
					r.mode = MODE_APPEND;
					r.decoded_ok = ($urandom_range(9) != 0);
					send_req(r, 1'b0, '0);
				end
				n = $urandom_range(6, 1);
				repeat (n) begin
					r = random_req();
					r.mode = $urandom_range(1) ? MODE_FIND : MODE_LOWER;
					idx = (model_count != 0) ? $urandom_range(model_count - 1) : 0;
					case ($urandom_range(3))
						0: if (model_count != 0) r.address = model_addr[idx];
						1: if (model_count != 0)
							r.address = $urandom_range(1) ? model_addr[idx] + 1
								: model_addr[idx] - 1;
						2: ;
						default: r.address = $urandom_range(1) ? '0 : '1;
					endcase
					send_req(r, 1'b0, '0);
				end
			end
		end
	endtask

	task automatic fill_large_table();
		iaidx_req_t  r;
		int unsigned idx;
		r = random_req();
		r.mode = MODE_CLEAR;
		send_req(r, 1'b0, '0);
		r = random_req();
		r.mode = MODE_SECTION;
		r.address[VA_W-1] = 1'b0;  // no wrap across the whole fill
		send_req(r, 1'b0, '0);
		while (model_count < FILL_ENTRIES) begin
			r = random_req();
			r.mode = MODE_APPEND;
			r.decoded_ok = ($urandom_range(15) != 0);
			send_req(r, 1'b0, '0);
		end
		repeat (12) begin
			r = random_req();
			r.mode = $urandom_range(1) ? MODE_FIND : MODE_LOWER;
			idx = $urandom_range(model_count - 1);
			case ($urandom_range(3))
				0: r.address = model_addr[idx];
				1: r.address = model_addr[idx] + 1;
				2: r.address = '0;
				default: r.address = '1;
			endcase
			send_req(r, 1'b0, '0);
		end
		r = random_req();
		r.mode = MODE_SECTION;
		send_req(r, 1'b0, '0);
		r.mode = MODE_SPARE7;
		send_req(r, 1'b0, '0);
		r.mode = MODE_CLEAR;
		send_req(r, 1'b0, '0);
	endtask

	// response side: random stalls, plus one long hold on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1)
					@(negedge clk);
			end else begin
				out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic flag_mismatch(input string what, input iaidx_rsp_t exp,
			input iaidx_rsp_t act);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("response %0d %s: expected status %0d position %0d, %s %0d %s %0d",
				checked_total, what, exp.status, exp.position,
				"got status", act.status, "position", act.position);
	endtask

	initial begin
		iaidx_rsp_t exp;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (due_responses.size() == 0) begin
					flag_mismatch("with none outstanding", '0, out_data);
				end else begin
					exp = due_responses.pop_front();
					if (out_data.status !== exp.status)
						flag_mismatch("status", exp, out_data);
					else if (out_data.position !== exp.position)
						flag_mismatch("position", exp, out_data);
				end
				checked_total++;
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("stalled for %0d cycles with %0d responses outstanding",
			STALL_LIMIT, due_responses.size());
		$display("instruction_address_index_search: mismatch");
		$finish;
	end

	initial begin
		// empty table, spare modes
		add_row(MODE_LOWER, '0, '0, 4'd1, 1'b1, 1'b1, STAT_OK, 0);
		add_row(MODE_FIND, '1, '1, 4'd15, 1'b1, 1'b1, STAT_MISS, 0);
		add_row(MODE_SPARE5, '1, '1, 4'd15, 1'b1, 1'b1, STAT_OK, 0);
		add_row(MODE_SPARE6, '0, '0, 4'd0, 1'b0, 1'b1, STAT_OK, 0);
		add_row(MODE_SPARE7, '1, '0, 4'd8, 1'b1, 1'b1, STAT_OK, 0);
		// short section: full length, zero length, failed decode, length one
		add_row(MODE_SECTION, 64'h1000, 32'h200, 4'd0, 1'b0, 1'b1, STAT_OK, 0);
		add_row(MODE_APPEND, '1, '1, 4'd15, 1'b1, 1'b1, STAT_OK, 0);
		add_row(MODE_APPEND, '0, '0, 4'd0, 1'b1, 1'b1, STAT_OK, 1);
		add_row(MODE_APPEND, '0, '0, 4'd7, 1'b0, 1'b1, STAT_OK, 2);
		add_row(MODE_APPEND, '0, '0, 4'd1, 1'b1, 1'b1, STAT_OK, 3);
		add_row(MODE_FIND, 64'h1000, '0, 4'd0, 1'b0, 1'b0, STAT_OK, 0);
		add_row(MODE_FIND, 64'h100f, '0, 4'd0, 1'b0, 1'b0, STAT_OK, 0);
		add_row(MODE_FIND, 64'h1005, '0, 4'd0, 1'b0, 1'b0, STAT_OK, 0);
		add_row(MODE_LOWER, '0, '0, 4'd0, 1'b0, 1'b0, STAT_OK, 0);
		add_row(MODE_LOWER, '1, '0, 4'd0, 1'b0, 1'b0, STAT_OK, 0);
		// running position wraps past the top of both spaces
		add_row(MODE_SECTION, 64'hffff_ffff_ffff_fffe, '1, 4'd0, 1'b0, 1'b1, STAT_OK, 4);
		add_row(MODE_APPEND, '0, '0, 4'd15, 1'b1, 1'b1, STAT_OK, 4);
		add_row(MODE_APPEND, '0, '0, 4'd15, 1'b0, 1'b1, STAT_OK, 5);
		add_row(MODE_LOWER, 64'hd, '0, 4'd0, 1'b0, 1'b0, STAT_OK, 0);
		add_row(MODE_FIND, 64'hffff_ffff_ffff_fffe, '0, 4'd0, 1'b0, 1'b0, STAT_OK, 0);
		// clear keeps the running position
		add_row(MODE_CLEAR, '1, '1, 4'd15, 1'b1, 1'b1, STAT_OK, 0);
		add_row(MODE_LOWER, '1, '0, 4'd0, 1'b0, 1'b1, STAT_OK, 0);
		add_row(MODE_APPEND, '0, '0, 4'd3, 1'b1, 1'b1, STAT_OK, 0);
		add_row(MODE_FIND, 64'he, '0, 4'd0, 1'b0, 1'b0, STAT_OK, 0);
		add_row(MODE_SECTION, '0, '0, 4'd0, 1'b0, 1'b1, STAT_OK, 1);

		repeat (10)
			@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 30;
		recv_idle_pct = 76;
		foreach (directed_rows[i])
			send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
		run_random(250);

		send_idle_pct = 76;
		recv_idle_pct = 30;
		run_random(250);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_pending = 1;
		run_random(250);
		fill_large_table();

		@(negedge clk);
		in_valid <= 1'b0;
		while (due_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("%0d requests: %0d appends (%0d to a full table), %0d exact finds %s",
			sent_total, mode_seen[MODE_APPEND], full_appends, mode_seen[MODE_FIND],
			$sformatf("(%0d hits), %0d lower bounds", exact_hits, mode_seen[MODE_LOWER]));
		$display("%0d section starts, %0d clears, %0d spare-mode requests; %s",
			mode_seen[MODE_SECTION], mode_seen[MODE_CLEAR],
			mode_seen[MODE_SPARE5] + mode_seen[MODE_SPARE6] + mode_seen[MODE_SPARE7],
			$sformatf("%0d responses checked, table peaked at %0d",
				checked_total, peak_count));
		if (mismatch_count == 0 && due_responses.size() == 0)
			$display("instruction_address_index_search: match");
		else
			$display("instruction_address_index_search: mismatch");
		$finish;
	end

endmodule
